// ===== design/assert_macros.svh =====
// Assertion macros shared by the blend datapath.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define RCBS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RCBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rcbs_pkg.sv =====
// Shared widths and types for the root-sum-square color blend.
// No dependencies; every other file of the block but assert_macros.svh imports this package.
package rcbs_pkg;

    // Channel layout: index 0 is blue, 1 green, 2 red.
    localparam int CH_N    = 3;
    localparam int FIELD_W = 16;
    localparam int SQ_W    = 2 * FIELD_W;
    localparam int SUM_W   = SQ_W + 1;
    // Radicand padded to an even width so each cell takes one bit pair.
    localparam int RAD_W   = SUM_W + 1;
    localparam int ROOT_W  = RAD_W / 2;
    // Remainder stays below 2^(ROOT_W+1); two more bits for the shifted trial value.
    localparam int REM_W   = ROOT_W + 3;
    localparam int CELL_N  = ROOT_W;

    typedef logic [FIELD_W-1:0] field_t;
    typedef field_t [CH_N-1:0] color_t;

    // Per-channel square-root working set handed from cell to cell.
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
        logic [RAD_W-1:0]  rad;
    } sqrt_lane_t;

    typedef sqrt_lane_t [CH_N-1:0] lane_arr_t;

endpackage

// ===== design/rcbs_in_if.sv =====
// Request channel carrying the two input colors.
// Depends on rcbs_pkg for the field type.
interface rcbs_in_if;
    import rcbs_pkg::*;

    logic   valid;
    logic   ready;
    field_t first_blue;
    field_t first_green;
    field_t first_red;
    field_t second_blue;
    field_t second_green;
    field_t second_red;

    modport source (
        output valid, first_blue, first_green, first_red,
        output second_blue, second_green, second_red,
        input  ready
    );

    modport sink (
        input  valid, first_blue, first_green, first_red,
        input  second_blue, second_green, second_red,
        output ready
    );
endinterface

// ===== design/rcbs_out_if.sv =====
// Request channel carrying the blended color.
// Depends on rcbs_pkg for the field type.
interface rcbs_out_if;
    import rcbs_pkg::*;

    logic   valid;
    logic   ready;
    field_t blend_blue;
    field_t blend_green;
    field_t blend_red;

    modport source (
        output valid, blend_blue, blend_green, blend_red,
        input  ready
    );

    modport sink (
        input  valid, blend_blue, blend_green, blend_red,
        output ready
    );
endinterface

// ===== design/rcbs_front.sv =====
// Front end of the blend pipeline: squares both colors, then sums per channel.
// Depends on rcbs_pkg; feeds the first square-root cell.
module rcbs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rcbs_pkg::color_t   first,
    input  rcbs_pkg::color_t   second,
    output logic               out_valid,
    output rcbs_pkg::lane_arr_t out_lanes
);
    import rcbs_pkg::*;

    logic                      sq_valid_reg;
    logic [CH_N-1:0][SQ_W-1:0] sq_a_reg;
    logic [CH_N-1:0][SQ_W-1:0] sq_b_reg;
    logic                      sum_valid_reg;
    logic [CH_N-1:0][SUM_W-1:0] sum_reg;
    logic [CH_N-1:0][SQ_W-1:0] sq_a_next;
    logic [CH_N-1:0][SQ_W-1:0] sq_b_next;
    logic [CH_N-1:0][SUM_W-1:0] sum_next;

    // One 16x16 product per operand and channel.
    always_comb
    begin
        for (int k = 0; k < CH_N; k++)
        begin
            sq_a_next[k] = SQ_W'(first[k]) * SQ_W'(first[k]);
            sq_b_next[k] = SQ_W'(second[k]) * SQ_W'(second[k]);
            sum_next[k]  = SUM_W'(sq_a_reg[k]) + SUM_W'(sq_b_reg[k]);
        end
    end

    // Valid bits of both stages move with the global enable.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg  <= in_valid;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_a_reg <= sq_a_next;
            sq_b_reg <= sq_b_next;
            sum_reg  <= sum_next;
        end
    end

    // The sum enters the root chain with an empty root and remainder.
    always_comb
    begin
        for (int k = 0; k < CH_N; k++)
        begin
            out_lanes[k].root = '0;
            out_lanes[k].rem  = '0;
            out_lanes[k].rad  = RAD_W'(sum_reg[k]);
        end
    end

    assign out_valid = sum_valid_reg;

endmodule

// ===== design/rcbs_cell.sv =====
// One cell of the square-root chain: settles one root bit for all three channels.
// Depends on rcbs_pkg; instantiated in a row by the top level.
module rcbs_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  rcbs_pkg::lane_arr_t in_lanes,
    output logic                out_valid,
    output rcbs_pkg::lane_arr_t out_lanes
);
    import rcbs_pkg::*;

    logic      valid_reg;
    lane_arr_t lanes_reg;
    lane_arr_t lanes_next;
    logic [REM_W-1:0] trial_rem;
    logic [REM_W-1:0] trial_sub;

    // Restoring digit step: bring down two radicand bits and try root*4+1.
    always_comb
    begin
        trial_rem = '0;
        trial_sub = '0;
        for (int k = 0; k < CH_N; k++)
        begin
            trial_rem = {in_lanes[k].rem[REM_W-3:0], in_lanes[k].rad[RAD_W-1 -: 2]};
            trial_sub = REM_W'({in_lanes[k].root, 2'b01});
            lanes_next[k].rad = {in_lanes[k].rad[RAD_W-3:0], 2'b00};
            if (trial_rem >= trial_sub)
            begin
                lanes_next[k].rem  = trial_rem - trial_sub;
                lanes_next[k].root = {in_lanes[k].root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                lanes_next[k].rem  = trial_rem;
                lanes_next[k].root = {in_lanes[k].root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

endmodule

// ===== design/rss_color_blend_sat_top.sv =====
// Top level of the root-sum-square color blend with saturation.
// Depends on rcbs_pkg, rcbs_in_if, rcbs_out_if, rcbs_front, rcbs_cell, assert_macros.svh.
//
// Usage:
//   colors (sink) takes one request per cycle holding two BGR colors, UQ1.15 per channel.
//   blend (source) returns one request per input: per channel floor(sqrt(a*a + b*b)),
//   limited to 1.0 (or to 65535 when FRAC_BITS puts 1.0 beyond the field).
//   From acceptance to blend.valid a request passes a squaring stage, a summing
//   stage, 17 square-root cells that each settle one root bit, and the output register.
//   Throughput is one color per cycle unless stalled; every stage moves on one enable.
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   colors.ready drops in the same cycle; it returns as soon as the result is taken.
//   Reset clears the valid bit of every stage; no item is in flight after it.
//   The block keeps no state between items.
`include "assert_macros.svh"

module rss_color_blend_sat_top #(
    parameter int FRAC_BITS = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    rcbs_in_if.sink           colors,
    rcbs_out_if.source        blend
);
    import rcbs_pkg::*;

    localparam logic [ROOT_W-1:0] SAT_LIMIT =
        ROOT_W'((FRAC_BITS >= FIELD_W) ? (2**FIELD_W - 1) : (2**FRAC_BITS));

    logic      en;
    color_t    first;
    color_t    second;
    logic      vld   [CELL_N+1];
    lane_arr_t lanes [CELL_N+1];
    logic      out_valid_reg;
    color_t    out_color_reg;
    color_t    out_color_next;
    logic      in_fire;
    logic      out_stall;
    logic      sat_ok;
    logic      rem_ok;

    // The pipeline moves whenever the output register is empty or being drained.
    assign en           = !out_valid_reg || blend.ready;
    assign colors.ready = en;

    assign first  = {colors.first_red, colors.first_green, colors.first_blue};
    assign second = {colors.second_red, colors.second_green, colors.second_blue};

    // Squares and sums.
    rcbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (colors.valid),
        .first     (first),
        .second    (second),
        .out_valid (vld[0]),
        .out_lanes (lanes[0])
    );

    // Square-root chain, one root bit per cell.
    for (genvar i = 0; i < CELL_N; i++)
    begin : g_cell
        rcbs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[i]),
            .in_lanes  (lanes[i]),
            .out_valid (vld[i+1]),
            .out_lanes (lanes[i+1])
        );
    end

    // Saturate each channel root at the limit.
    always_comb
    begin
        for (int k = 0; k < CH_N; k++)
        begin
            if (lanes[CELL_N][k].root > SAT_LIMIT)
            begin
                out_color_next[k] = SAT_LIMIT[FIELD_W-1:0];
            end
            else
            begin
                out_color_next[k] = lanes[CELL_N][k].root[FIELD_W-1:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld[CELL_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_color_reg <= out_color_next;
        end
    end

    assign blend.valid       = out_valid_reg;
    assign blend.blend_blue  = out_color_reg[0];
    assign blend.blend_green = out_color_reg[1];
    assign blend.blend_red   = out_color_reg[2];

    // Terms used by the checks below.
    assign in_fire   = colors.valid && colors.ready;
    assign out_stall = blend.valid && !blend.ready;
    assign sat_ok    = (blend.blend_blue <= SAT_LIMIT[FIELD_W-1:0])
                    && (blend.blend_green <= SAT_LIMIT[FIELD_W-1:0])
                    && (blend.blend_red <= SAT_LIMIT[FIELD_W-1:0]);
    assign rem_ok    = (lanes[CELL_N][0].rem[REM_W-1:REM_W-2] == 2'b00)
                    && (lanes[CELL_N][1].rem[REM_W-1:REM_W-2] == 2'b00)
                    && (lanes[CELL_N][2].rem[REM_W-1:REM_W-2] == 2'b00);

    // Checks on the pipeline.
    `RCBS_ASSERT(a_sat_limit, blend.valid, sat_ok, "blended channel above saturation limit")
    `RCBS_ASSERT(a_stall_source, !colors.ready, out_stall, "input stalled without a stalled result")
    `RCBS_ASSERT(a_rem_bound, vld[CELL_N], rem_ok, "square-root remainder out of range")
    `RCBS_ASSERT_NEXT(a_accept_enters, in_fire, u_front.sq_valid_reg, "request lost at entry")

endmodule

// ===== dv/tb_rss_color_blend_sat_top.sv =====
// Testbench for the root-sum-square color blend with saturation.
// Depends on rcbs_pkg, rcbs_in_if, rcbs_out_if and rss_color_blend_sat_top.
// Drives color pairs, predicts each blended color and checks the results in order.
module tb_rss_color_blend_sat_top;
    import rcbs_pkg::*;

    localparam int FRAC_BITS = 15;
    localparam int unsigned UNITY = 32'd1 << FRAC_BITS;
    localparam longint unsigned CEILING = (UNITY > 32'd65535) ? 64'd65535 : 64'(UNITY);
    localparam int PIPE_DEPTH = 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        color_t first;
        color_t second;
    } color_pair_t;

    logic clk;
    logic rst_n;

    rcbs_in_if  colors();
    rcbs_out_if blend();

    int src_idle_pct;
    int snk_idle_pct;
    int mismatch_count = 0;
    int cycle_count = 0;
    color_t blend_expect_q[$];

    rss_color_blend_sat_top #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .colors(colors.sink),
        .blend(blend.source)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Floor of the square root, settled one result bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned radicand);
        longint unsigned acc;
        longint unsigned trial;
        acc = 0;
        for (int i = 17; i >= 0; i--)
        begin
            trial = acc | (64'd1 << i);
            if (trial * trial <= radicand)
                acc = trial;
        end
        return acc;
    endfunction

    // Blended color: per channel root of the exact sum of squares, limited to 1.0.
    function automatic color_t predict_blend(input color_pair_t px);
        color_t res;
        longint unsigned a;
        longint unsigned b;
        longint unsigned root;
        for (int ch = 0; ch < CH_N; ch++)
        begin
            a = px.first[ch];
            b = px.second[ch];
            root = floor_root(a * a + b * b);
            if (root > CEILING)
                root = CEILING;
            res[ch] = field_t'(root);
        end
        return res;
    endfunction

    // Random channel value, weighted toward zero, full scale and the saturation knee.
    function automatic field_t rand_channel();
        case ($urandom_range(9))
            0: return field_t'($urandom_range(65535));
            1: return field_t'(UNITY);
            2: return '0;
            3, 4: return field_t'($urandom_range(UNITY, 20000));
            default: return field_t'($urandom_range(UNITY));
        endcase
    endfunction

    function automatic color_pair_t make_pair(input longint unsigned fb,
                                              input longint unsigned fg,
                                              input longint unsigned fr,
                                              input longint unsigned sb,
                                              input longint unsigned sg,
                                              input longint unsigned sr);
        color_pair_t px;
        px.first  = {field_t'(fr), field_t'(fg), field_t'(fb)};
        px.second = {field_t'(sr), field_t'(sg), field_t'(sb)};
        return px;
    endfunction

    // Send one request, idling first at the current sender rate.
    task automatic send_color(input color_pair_t px);
        while ($urandom_range(99) < src_idle_pct)
        begin
            colors.valid <= 1'b0;
            @(posedge clk);
        end
        colors.valid        <= 1'b1;
        colors.first_blue   <= px.first[0];
        colors.first_green  <= px.first[1];
        colors.first_red    <= px.first[2];
        colors.second_blue  <= px.second[0];
        colors.second_green <= px.second[1];
        colors.second_red   <= px.second[2];
        @(posedge clk);
        while (!colors.ready)
            @(posedge clk);
    endtask

    // Hold the sender off until every predicted blend has come back.
    task automatic wait_drained();
        colors.valid <= 1'b0;
        @(posedge clk);
        while (blend_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stalls at the current rate.
    always @(posedge clk)
    begin
        blend.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Predict on each accepted request, then check each accepted result.
    always @(posedge clk)
    begin
        color_t exp_c;
        if (rst_n && colors.valid && colors.ready)
        begin
            blend_expect_q.push_back(predict_blend(make_pair(
                colors.first_blue, colors.first_green, colors.first_red,
                colors.second_blue, colors.second_green, colors.second_red)));
        end
        if (rst_n && blend.valid && blend.ready)
        begin
            if (blend_expect_q.size() == 0)
            begin
                $error("unexpected blend request: blue %0d green %0d red %0d",
                       blend.blend_blue, blend.blend_green, blend.blend_red);
                mismatch_count++;
            end
            else
            begin
                exp_c = blend_expect_q.pop_front();
                if (blend.blend_blue !== exp_c[0])
                begin
                    $error("blend_blue: expected %0d, actual %0d", exp_c[0], blend.blend_blue);
                    mismatch_count++;
                end
                if (blend.blend_green !== exp_c[1])
                begin
                    $error("blend_green: expected %0d, actual %0d",
                           exp_c[1], blend.blend_green);
                    mismatch_count++;
                end
                if (blend.blend_red !== exp_c[2])
                begin
                    $error("blend_red: expected %0d, actual %0d", exp_c[2], blend.blend_red);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Zero, exactly 1.0, both at 1.0, out-of-range inputs, alternating bit patterns and small values.
    task automatic test_extremes();
        send_color(make_pair(0, 0, 0, 0, 0, 0));
        send_color(make_pair(UNITY, 0, 0, 0, UNITY, 0));
        send_color(make_pair(0, 0, UNITY, 0, 0, 0));
        send_color(make_pair(UNITY, UNITY, UNITY, UNITY, UNITY, UNITY));
        send_color(make_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_color(make_pair(16'hFFFF, 0, 1, 0, 16'hFFFF, 1));
        send_color(make_pair(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_color(make_pair(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        send_color(make_pair(1, 2, 3, 1, 2, 3));
        send_color(make_pair(32767, 1, 16384, 0, 32767, 16384));
    endtask

    // Sums just below and just above the saturation point.
    task automatic test_saturation_knee();
        send_color(make_pair(23170, 23170, 23171, 23170, 23171, 23171));
        send_color(make_pair(32767, 32767, 256, 255, 256, 32767));
        send_color(make_pair(19660, 26214, 32768, 26214, 19660, 1));
        send_color(make_pair(18000, 30000, 32000, 27000, 12000, 7000));
    endtask

    // Scalar blend: the second color carries one value in all three channels.
    task automatic test_scalar_blend();
        send_color(make_pair(100, 20000, UNITY, 12345, 12345, 12345));
        send_color(make_pair(0, 16'hFFFF, 23170, 23170, 23170, 23170));
        send_color(make_pair(30000, 5, 9999, UNITY, UNITY, UNITY));
        send_color(make_pair(UNITY, UNITY, UNITY, 0, 0, 0));
    endtask

    // Random color pairs; some are scalar blends.
    task automatic test_random_pairs(input int count, input int src_pct, input int snk_pct);
        color_pair_t px;
        field_t s;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int n = 0; n < count; n++)
        begin
            for (int ch = 0; ch < CH_N; ch++)
            begin
                px.first[ch]  = rand_channel();
                px.second[ch] = rand_channel();
            end
            if ($urandom_range(9) == 0)
            begin
                s = rand_channel();
                px.second = {s, s, s};
            end
            send_color(px);
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        colors.valid        <= 1'b0;
        colors.first_blue   <= '0;
        colors.first_green  <= '0;
        colors.first_red    <= '0;
        colors.second_blue  <= '0;
        colors.second_green <= '0;
        colors.second_red   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_saturation_knee();
        test_scalar_blend();
        wait_drained();

        test_random_pairs(370, 33, 46);
        wait_drained();
        test_random_pairs(370, 46, 33);
        test_random_pairs(360, 0, 0);

        wait_drained();
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
